@@ hw/rtl/slus_pkg.sv @@
// Shared types, codes and constant tables for the segment LCD update sequencer.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package slus_pkg;

	localparam int NUM_SLOTS = 7;

	typedef logic [2:0] slus_slot_t;

	// Shadow slots, one per display address
	localparam slus_slot_t S03 = 3'd0;
	localparam slus_slot_t S06 = 3'd1;
	localparam slus_slot_t S07 = 3'd2;
	localparam slus_slot_t S0A = 3'd3;
	localparam slus_slot_t S0B = 3'd4;
	localparam slus_slot_t S0E = 3'd5;
	localparam slus_slot_t S0F = 3'd6;

	// Command codes
	localparam logic [2:0] CMD_INIT    = 3'd0;
	localparam logic [2:0] CMD_NUMBER  = 3'd1;
	localparam logic [2:0] CMD_WIND    = 3'd2;
	localparam logic [2:0] CMD_CHANNEL = 3'd3;
	localparam logic [2:0] CMD_ICON    = 3'd4;
	localparam logic [2:0] CMD_FAN     = 3'd5;

	// Icon codes used by name
	localparam logic [3:0] ICON_FAN_CENTRE = 4'd6;
	localparam logic [3:0] ICON_LEAF1      = 4'd7;
	localparam logic [3:0] ICON_LEAF2      = 4'd8;
	localparam logic [3:0] ICON_LAST       = 4'd8;

	// Controller command bytes and masks
	localparam logic [7:0] MODE_BYTE         = 8'h00;
	localparam logic [7:0] FIXED_ADDR_BYTE   = 8'h44;
	localparam logic [7:0] DISPLAY_ON_BYTE   = 8'h93;
	localparam logic [7:0] WIND_KEEP_MASK    = 8'h30;
	localparam logic [7:0] CHANNEL_KEEP_MASK = 8'h80;

	localparam logic [7:0] WIND_MAX    = 8'd6;
	localparam logic [7:0] CHANNEL_MAX = 8'd7;

	// Init run layout: two command bytes, seven zeroed addresses, display on
	localparam logic [3:0] INIT_IDX_MODE   = 4'd0;
	localparam logic [3:0] INIT_IDX_FIXED  = 4'd1;
	localparam logic [3:0] INIT_FIRST_PAIR = 4'd2;
	localparam logic [3:0] INIT_LAST_IDX   = 4'd9;

	// Job kinds
	localparam logic JOB_LIST = 1'b0;
	localparam logic JOB_INIT = 1'b1;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] value;
		logic [3:0] icon_select;
		logic       icon_on;
		logic       fan_enabled;
		logic [2:0] fan_speed;
		logic       fan_phase;
	} slus_in_t;

	// One queued command: either the fixed init run or a list of up to four writes
	typedef struct packed {
		logic            kind;
		logic [1:0]      cnt_m1;
		logic [3:0][7:0] addr;
		logic [3:0][7:0] data;
	} slus_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} slus_fifo_stat_t;

	function automatic logic [7:0] addr_of(input slus_slot_t s);
		logic [7:0] a;
		unique case (s)
			S03:     a = 8'hc3;
			S06:     a = 8'hc6;
			S07:     a = 8'hc7;
			S0A:     a = 8'hca;
			S0B:     a = 8'hcb;
			S0E:     a = 8'hce;
			S0F:     a = 8'hcf;
			default: a = 8'hcf;
		endcase
		return a;
	endfunction

	function automatic logic [7:0] seg_digit(input logic [3:0] d);
		logic [7:0] p;
		unique case (d)
			4'd0:    p = 8'hF5;
			4'd1:    p = 8'h05;
			4'd2:    p = 8'hD3;
			4'd3:    p = 8'h97;
			4'd4:    p = 8'h27;
			4'd5:    p = 8'hB6;
			4'd6:    p = 8'hF6;
			4'd7:    p = 8'h15;
			4'd8:    p = 8'hF7;
			4'd9:    p = 8'hB7;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] wind_bar(input logic [2:0] lvl);
		logic [7:0] p;
		unique case (lvl)
			3'd0:    p = 8'h00;
			3'd1:    p = 8'h40;
			3'd2:    p = 8'hc0;
			3'd3:    p = 8'hc8;
			3'd4:    p = 8'hcc;
			3'd5:    p = 8'hce;
			3'd6:    p = 8'hcf;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

	function automatic logic [2:0] ch_lo(input logic [2:0] ch);
		logic [2:0] p;
		unique case (ch)
			3'd0:    p = 3'h0;
			3'd1:    p = 3'h4;
			3'd2:    p = 3'h2;
			3'd3:    p = 3'h1;
			3'd4:    p = 3'h6;
			3'd5:    p = 3'h3;
			3'd6:    p = 3'h5;
			default: p = 3'h7;
		endcase
		return p;
	endfunction

	function automatic slus_slot_t icon_slot(input logic [3:0] sel);
		slus_slot_t s;
		unique case (sel)
			4'd0:    s = S0E;
			4'd1:    s = S03;
			4'd2:    s = S03;
			4'd3:    s = S03;
			4'd4:    s = S03;
			4'd5:    s = S06;
			4'd6:    s = S0F;
			4'd7:    s = S0E;
			4'd8:    s = S0F;
			default: s = S03;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] icon_bit(input logic [3:0] sel);
		logic [7:0] b;
		unique case (sel)
			4'd0:    b = 8'h08;
			4'd1:    b = 8'h10;
			4'd2:    b = 8'h20;
			4'd3:    b = 8'h40;
			4'd4:    b = 8'h80;
			4'd5:    b = 8'h08;
			4'd6:    b = 8'h20;
			4'd7:    b = 8'h10;
			4'd8:    b = 8'h10;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/segment_lcd_update_sequencer.sv @@
// Path: an accepted request is queued in the job queue, and the write sequencer then loads its
// first write into the output register, which drives the master side.
// Throughput: one request per cycle while the job queue has room; one write per cycle out
// while the master side is ready; a command's run is 1 to 10 writes (init has 10).
// Reset (arst_n low, asynchronous): clears the shadow bytes, empties the job queue and the
// output register; no clearing pass is needed afterwards.
`default_nettype none

module segment_lcd_update_sequencer
	import slus_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [7:0] value, [11:8] icon_select, [12] icon_on, [13] fan_enabled,
	// [16:14] fan_speed, [17] fan_phase, [23:18] zero
	input  wire logic [23:0] s_axis_tdata,
	// [2:0] cmd
	input  wire logic [2:0]  s_axis_tuser,

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] lead_byte, [15:8] data_byte
	output logic [15:0]      m_axis_tdata,
	// [0] has_data
	output logic             m_axis_tuser,
	output logic             m_axis_tlast
);

	slus_in_t        in_req;
	slus_job_t       push_job, head;
	slus_fifo_stat_t stat;
	logic            push, pop;
	logic [7:0]      out_lead, out_data;

	// Unpack the request fields from the slave side
	assign in_req.cmd         = s_axis_tuser;
	assign in_req.value       = s_axis_tdata[7:0];
	assign in_req.icon_select = s_axis_tdata[11:8];
	assign in_req.icon_on     = s_axis_tdata[12];
	assign in_req.fan_enabled = s_axis_tdata[13];
	assign in_req.fan_speed   = s_axis_tdata[16:14];
	assign in_req.fan_phase   = s_axis_tdata[17];

	// Front end: decode each request, update the shadow bytes at once so the next
	// request sees them, and queue the resulting write list. Ignored codes queue nothing.
	slus_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_req   (in_req),
		.stat     (stat),
		.push     (push),
		.push_job (push_job)
	);

	// Job queue: lets the front keep taking requests while the back drains writes
	slus_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	// Back end: walk each job one write per cycle, while the output register is free, into it
	slus_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.stat         (stat),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_lead     (out_lead),
		.out_has_data (m_axis_tuser),
		.out_data     (out_data),
		.out_last     (m_axis_tlast)
	);

	assign m_axis_tdata = {out_data, out_lead};

`ifndef SYNTH
	// Never queue a job into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("job pushed into full queue");

	// Never take a job from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("job popped from empty queue");

	// A lone command byte carries a zero data byte
	a_cmd_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:8] == 8'h00))
		else $error("command byte with nonzero data");

	// Every address write targets a display address
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:6] == 2'b11))
		else $error("address write outside display range");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/slus_front.sv @@
// Front end: accepts display commands, updates the shadow bytes and builds a job.
// Depends on slus_pkg.
`default_nettype none

module slus_front
	import slus_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire slus_in_t        in_req,
	input  wire slus_fifo_stat_t stat,
	output logic                 push,
	output slus_job_t            push_job
);

	logic [7:0] shadow_q [NUM_SLOTS];
	logic [7:0] shadow_d [NUM_SLOTS];
	logic       job_valid;
	logic       accept;

	// number decode
	logic [1:0]  hund;
	logic [7:0]  hund100;
	logic [7:0]  rem8;
	logic [6:0]  rem;
	logic [14:0] rem_prod;
	logic [3:0]  tens;
	logic [6:0]  tens10;
	logic [6:0]  ones7;
	logic [7:0]  hund_pat, tens_pat, ones_pat;

	// other commands
	logic [7:0] wind_v;
	logic [2:0] ch_p;
	logic [7:0] ch_e, ch_b;
	slus_slot_t ic_slot;
	logic [7:0] ic_bit, ic_v;
	logic       leaf1, leaf2;
	logic [7:0] fan_f1, fan_e, fan_f2;

	assign in_ready = !stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && job_valid;

	always_comb begin
		hund     = (in_req.value >= 8'd200) ? 2'd2 : ((in_req.value >= 8'd100) ? 2'd1 : 2'd0);
		hund100  = (hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0);
		rem8     = in_req.value - hund100;
		rem      = rem8[6:0];
		// divide by ten through the reciprocal 205/2048, exact below 1029
		rem_prod = {8'b0, rem} * 15'd205;
		tens     = rem_prod[14:11];
		tens10   = {tens[3:0], 3'b000} + {2'b00, tens, 1'b0};
		ones7    = rem - tens10;
		hund_pat = seg_digit({2'b00, hund});
		tens_pat = seg_digit(tens);
		ones_pat = seg_digit(ones7[3:0]);
	end

	always_comb begin
		wind_v  = (shadow_q[S0F] & WIND_KEEP_MASK)
			| ((in_req.value <= WIND_MAX) ? wind_bar(in_req.value[2:0]) : 8'h00);
		ch_p    = (in_req.value <= CHANNEL_MAX) ? ch_lo(in_req.value[2:0]) : 3'h0;
		ch_e    = (shadow_q[S0E] & CHANNEL_KEEP_MASK) | {5'b0, ch_p};
		ch_b    = {1'b0, ch_p, 4'b0000};
		ic_slot = icon_slot(in_req.icon_select);
		ic_bit  = icon_bit(in_req.icon_select);
		ic_v    = in_req.icon_on ? (shadow_q[ic_slot] | ic_bit)
			: (shadow_q[ic_slot] & ~ic_bit);
		leaf1   = 1'b1;
		leaf2   = 1'b0;
		if (in_req.fan_enabled && in_req.fan_speed != 3'd0) begin
			leaf1 = in_req.fan_phase;
			leaf2 = !in_req.fan_phase;
		end
		fan_f1  = shadow_q[S0F] | icon_bit(ICON_FAN_CENTRE);
		fan_e   = leaf1 ? (shadow_q[S0E] | icon_bit(ICON_LEAF1))
			: (shadow_q[S0E] & ~icon_bit(ICON_LEAF1));
		fan_f2  = leaf2 ? (fan_f1 | icon_bit(ICON_LEAF2)) : (fan_f1 & ~icon_bit(ICON_LEAF2));
	end

	always_comb begin
		shadow_d  = shadow_q;
		job_valid = 1'b0;
		push_job  = '0;
		unique case (in_req.cmd)
			CMD_INIT: begin
				job_valid     = 1'b1;
				push_job.kind = JOB_INIT;
			end
			CMD_NUMBER: begin
				shadow_d[S0B]    = {4'h0, hund_pat[7:4]};
				shadow_d[S0A]    = hund_pat;
				shadow_d[S07]    = tens_pat;
				shadow_d[S06]    = ones_pat;
				job_valid        = 1'b1;
				push_job.kind    = JOB_LIST;
				push_job.cnt_m1  = 2'd3;
				push_job.addr[0] = addr_of(S0B);
				push_job.addr[1] = addr_of(S0A);
				push_job.addr[2] = addr_of(S07);
				push_job.addr[3] = addr_of(S06);
				// blank the leading digits on the glass
				push_job.data[0] = (in_req.value < 8'd100) ? 8'h00 : {4'h0, hund_pat[7:4]};
				push_job.data[1] = (in_req.value < 8'd100) ? 8'h00 : hund_pat;
				push_job.data[2] = (in_req.value < 8'd10) ? 8'h00 : tens_pat;
				push_job.data[3] = ones_pat;
			end
			CMD_WIND: begin
				shadow_d[S0F]    = wind_v;
				job_valid        = 1'b1;
				push_job.addr[0] = addr_of(S0F);
				push_job.data[0] = wind_v;
			end
			CMD_CHANNEL: begin
				shadow_d[S0E]    = ch_e;
				shadow_d[S0B]    = ch_b;
				job_valid        = 1'b1;
				push_job.cnt_m1  = 2'd1;
				push_job.addr[0] = addr_of(S0E);
				push_job.data[0] = ch_e;
				push_job.addr[1] = addr_of(S0B);
				push_job.data[1] = ch_b;
			end
			CMD_ICON: begin
				if (in_req.icon_select <= ICON_LAST) begin
					shadow_d[ic_slot] = ic_v;
					job_valid         = 1'b1;
					push_job.addr[0]  = addr_of(ic_slot);
					push_job.data[0]  = ic_v;
				end
			end
			CMD_FAN: begin
				shadow_d[S0F]    = fan_f2;
				shadow_d[S0E]    = fan_e;
				job_valid        = 1'b1;
				push_job.cnt_m1  = 2'd2;
				push_job.addr[0] = addr_of(S0F);
				push_job.data[0] = fan_f1;
				push_job.addr[1] = addr_of(S0E);
				push_job.data[1] = fan_e;
				push_job.addr[2] = addr_of(S0F);
				push_job.data[2] = fan_f2;
			end
			default: begin
				job_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				shadow_q[i] <= 8'h00;
			end
		end else if (accept) begin
			shadow_q <= shadow_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/slus_fifo.sv @@
// Short job queue between the front end and the write sequencer.
// Depends on slus_pkg.
`default_nettype none

module slus_fifo
	import slus_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire slus_job_t  push_job,
	input  wire logic       pop,
	output slus_job_t       head,
	output slus_fifo_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	slus_job_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/slus_back.sv @@
// Write sequencer: expands queued jobs into controller writes behind an output register.
// Depends on slus_pkg.
`default_nettype none

module slus_back
	import slus_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire slus_job_t       head,
	input  wire slus_fifo_stat_t stat,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_lead,
	output logic                 out_has_data,
	output logic [7:0]           out_data,
	output logic                 out_last
);

	slus_job_t  cur_job_q;
	logic       cur_valid_q;
	logic [3:0] idx_q;

	logic       out_valid_q;
	logic [7:0] out_lead_q, out_data_q;
	logic       out_has_q, out_last_q;

	slus_job_t  src_job;
	logic [3:0] src_idx;
	logic       src_valid;
	logic [3:0] pair_idx4;
	logic [7:0] w_lead, w_data;
	logic       w_has, w_last;
	logic       slot_free, adv;

	assign src_job   = cur_valid_q ? cur_job_q : head;
	assign src_idx   = cur_valid_q ? idx_q : '0;
	assign src_valid = cur_valid_q || !stat.empty;
	assign pair_idx4 = src_idx - INIT_FIRST_PAIR;
	assign slot_free = !out_valid_q || out_ready;
	assign adv       = src_valid && slot_free;
	assign pop       = adv && !cur_valid_q;

	always_comb begin
		w_lead = 8'h00;
		w_data = 8'h00;
		w_has  = 1'b0;
		w_last = 1'b0;
		if (src_job.kind == JOB_INIT) begin
			priority if (src_idx == INIT_IDX_MODE) begin
				w_lead = MODE_BYTE;
			end else if (src_idx == INIT_IDX_FIXED) begin
				w_lead = FIXED_ADDR_BYTE;
			end else if (src_idx == INIT_LAST_IDX) begin
				w_lead = DISPLAY_ON_BYTE;
				w_last = 1'b1;
			end else begin
				// clear one display address
				w_lead = addr_of(pair_idx4[2:0]);
				w_has  = 1'b1;
			end
		end else begin
			w_lead = src_job.addr[src_idx[1:0]];
			w_data = src_job.data[src_idx[1:0]];
			w_has  = 1'b1;
			w_last = (src_idx[1:0] == src_job.cnt_m1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				cur_valid_q <= !w_last;
				idx_q       <= src_idx + 1'b1;
			end
			if (slot_free) begin
				out_valid_q <= src_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cur_job_q  <= src_job;
			out_lead_q <= w_lead;
			out_data_q <= w_data;
			out_has_q  <= w_has;
			out_last_q <= w_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_lead     = out_lead_q;
	assign out_has_data = out_has_q;
	assign out_data     = out_data_q;
	assign out_last     = out_last_q;

endmodule

`default_nettype wire

@@ bench/slus_write_checker.sv @@
`timescale 1ns / 100ps
// Write checker for the segment LCD update sequencer: keeps its own shadow bytes, predicts
// the controller writes of every accepted request and compares the write stream in order.
// Depends on slus_pkg for slot indexes, command codes, icon codes and controller bytes.

module slus_write_checker
	import slus_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	// [7:0] value, [11:8] icon_select, [12] icon_on, [13] fan_enabled,
	// [16:14] fan_speed, [17] fan_phase, [23:18] zero
	input  wire logic [23:0] s_axis_tdata,
	// [2:0] cmd
	input  wire logic [2:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] lead_byte, [15:8] data_byte
	input  wire logic [15:0] m_axis_tdata,
	// [0] has_data
	input  wire logic        m_axis_tuser,
	input  wire logic        m_axis_tlast,
	output int               mismatch_count,
	output int               writes_pending
);

	typedef struct packed {
		logic [7:0] lead_byte;
		logic       has_data;
		logic [7:0] data_byte;
		logic       last;
	} lcd_write_t;

	// Lookup tables, entry 0 in the lowest bits
	localparam logic [7*8-1:0]  SLOT_ADDRS = {8'hcf, 8'hce, 8'hcb, 8'hca, 8'hc7, 8'hc6, 8'hc3};
	localparam logic [10*8-1:0] DIGIT_TAB = {8'hB7, 8'hF7, 8'h15, 8'hF6, 8'hB6,
		8'h27, 8'h97, 8'hD3, 8'h05, 8'hF5};
	localparam logic [7*8-1:0]  WIND_TAB  = {8'hcf, 8'hce, 8'hcc, 8'hc8, 8'hc0, 8'h40, 8'h00};
	localparam logic [8*4-1:0]  CHAN_TAB  = {4'h7, 4'h5, 4'h3, 4'h6, 4'h1, 4'h2, 4'h4, 4'h0};
	localparam logic [9*3-1:0]  ICON_SLOT_TAB = {S0F, S0E, S0F, S06, S03, S03, S03, S03, S0E};
	localparam logic [9*8-1:0]  ICON_MASK_TAB = {8'h10, 8'h10, 8'h20, 8'h08, 8'h80,
		8'h40, 8'h20, 8'h10, 8'h08};

	lcd_write_t expected_writes[$];
	logic [7:0] shadow [NUM_SLOTS];

	function automatic logic [7:0] slot_addr(input slus_slot_t s);
		return SLOT_ADDRS[int'(s)*8 +: 8];
	endfunction

	function automatic void queue_write(input logic [7:0] lead, input logic has_data,
			input logic [7:0] data);
		lcd_write_t w;
		w = {lead, has_data, data, 1'b0};
		expected_writes.push_back(w);
	endfunction

	function automatic void queue_slot(input slus_slot_t s);
		queue_write(slot_addr(s), 1'b1, shadow[s]);
	endfunction

	function automatic void apply_icon(input logic [3:0] sel, input logic lit);
		slus_slot_t s;
		logic [7:0] m;
		s = ICON_SLOT_TAB[int'(sel)*3 +: 3];
		m = ICON_MASK_TAB[int'(sel)*8 +: 8];
		shadow[s] = (shadow[s] & ~m) | (lit ? m : 8'h00);
	endfunction

	// Update the shadow bytes for one request and queue the writes it causes
	function automatic void predict_writes(input logic [2:0] cmd, input logic [23:0] req);
		logic [7:0] value;
		logic [3:0] sel;
		logic [2:0] chan;
		logic       leaf1;
		logic       leaf2;
		int         hundreds;
		int         tens;
		int         ones;
		int         first;
		lcd_write_t w;
		value = req[7:0];
		sel   = req[11:8];
		first = expected_writes.size();
		case (cmd)
			CMD_INIT: begin
				queue_write(MODE_BYTE, 1'b0, 8'h00);
				queue_write(FIXED_ADDR_BYTE, 1'b0, 8'h00);
				for (int i = 0; i < NUM_SLOTS; i++)
					queue_write(slot_addr(slus_slot_t'(i)), 1'b1, 8'h00);
				queue_write(DISPLAY_ON_BYTE, 1'b0, 8'h00);
			end
			CMD_NUMBER: begin
				hundreds = value / 100;
				tens     = (value / 10) % 10;
				ones     = value % 10;
				shadow[S0B] = DIGIT_TAB[hundreds*8 +: 8] >> 4;
				shadow[S0A] = DIGIT_TAB[hundreds*8 +: 8];
				shadow[S07] = DIGIT_TAB[tens*8 +: 8];
				shadow[S06] = DIGIT_TAB[ones*8 +: 8];
				// leading blanks go out as zero while the shadow keeps the digit
				if (value < 100) begin
					queue_write(slot_addr(S0B), 1'b1, 8'h00);
					queue_write(slot_addr(S0A), 1'b1, 8'h00);
				end else begin
					queue_slot(S0B);
					queue_slot(S0A);
				end
				if (value < 10)
					queue_write(slot_addr(S07), 1'b1, 8'h00);
				else
					queue_slot(S07);
				queue_slot(S06);
			end
			CMD_WIND: begin
				shadow[S0F] = shadow[S0F] & WIND_KEEP_MASK;
				if (value <= WIND_MAX)
					shadow[S0F] = shadow[S0F] | WIND_TAB[int'(value)*8 +: 8];
				queue_slot(S0F);
			end
			CMD_CHANNEL: begin
				chan = (value <= CHANNEL_MAX) ? CHAN_TAB[int'(value)*4 +: 3] : 3'd0;
				shadow[S0E] = (shadow[S0E] & CHANNEL_KEEP_MASK) | {5'd0, chan};
				shadow[S0B] = {1'b0, chan, 4'd0};
				queue_slot(S0E);
				queue_slot(S0B);
			end
			CMD_ICON: begin
				if (sel <= ICON_LAST) begin
					apply_icon(sel, req[12]);
					queue_slot(ICON_SLOT_TAB[int'(sel)*3 +: 3]);
				end
			end
			CMD_FAN: begin
				leaf1 = 1'b1;
				leaf2 = 1'b0;
				if (req[13] && req[16:14] != 3'd0) begin
					leaf1 = req[17];
					leaf2 = !req[17];
				end
				apply_icon(ICON_FAN_CENTRE, 1'b1);
				queue_slot(S0F);
				apply_icon(ICON_LEAF1, leaf1);
				queue_slot(S0E);
				apply_icon(ICON_LEAF2, leaf2);
				queue_slot(S0F);
			end
			default: ;
		endcase
		if (expected_writes.size() > first) begin
			w = expected_writes.pop_back();
			w.last = 1'b1;
			expected_writes.push_back(w);
		end
	endfunction

	function automatic void report_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		mismatch_count++;
		$error("%s: expected %0h, got %0h", name, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lcd_write_t got;
		lcd_write_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++)
				shadow[i] = 8'h00;
			expected_writes.delete();
			mismatch_count = 0;
			writes_pending <= 0;
		end else begin
			// check the write first: it always belongs to an earlier request
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[15:8], m_axis_tlast};
				if (expected_writes.size() == 0) begin
					mismatch_count++;
					$error("write with nothing pending: lead_byte %0h", got.lead_byte);
				end else begin
					want = expected_writes.pop_front();
					if (got.lead_byte !== want.lead_byte)
						report_field("lead_byte", want.lead_byte, got.lead_byte);
					if (got.has_data !== want.has_data)
						report_field("has_data", {7'd0, want.has_data},
							{7'd0, got.has_data});
					if (got.data_byte !== want.data_byte)
						report_field("data_byte", want.data_byte, got.data_byte);
					if (got.last !== want.last)
						report_field("last", {7'd0, want.last}, {7'd0, got.last});
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_writes(s_axis_tuser, s_axis_tdata);
			writes_pending <= expected_writes.size();
		end
	end

endmodule

@@ bench/segment_lcd_update_sequencer_tb.sv @@
`timescale 1ns / 100ps
// Top of the bench for the segment LCD update sequencer: clock, reset, request stimulus,
// write-side back-pressure and the verdict. Depends on slus_pkg and slus_write_checker.

module segment_lcd_update_sequencer_tb;
	import slus_pkg::*;

	// Command codes the block must ignore
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	// Icon codes used by the directed part
	localparam logic [3:0] ICON_PERCENT = 4'd5;
	localparam logic [3:0] ICON_UNUSED  = 4'd15;

	localparam int RANDOM_ITEMS = 116;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [7:0] value, [11:8] icon_select, [12] icon_on, [13] fan_enabled,
	// [16:14] fan_speed, [17] fan_phase, [23:18] zero
	logic [23:0] s_axis_tdata = '0;
	// [2:0] cmd
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] lead_byte, [15:8] data_byte
	logic [15:0] m_axis_tdata;
	// [0] has_data
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	int mismatch_count;
	int writes_pending;
	int cycle_count = 0;

	// Idling controls shared by the sender and the write-side receiver
	logic no_idle = 1'b0;
	logic long_hold_req = 1'b0;
	logic long_hold_taken = 1'b0;
	int   sink_stall = 0;

	segment_lcd_update_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	slus_write_checker write_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.mismatch_count (mismatch_count),
		.writes_pending (writes_pending)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop in case the block hangs somewhere
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Write-side receiver: mostly ready, short stalls with an occasional long one, and a
	// single long hold-off on request so the job queue fills and the input side stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (sink_stall > 0) begin
			m_axis_tready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else if (long_hold_req && !long_hold_taken) begin
			m_axis_tready <= 1'b0;
			sink_stall <= LONG_HOLD;
			long_hold_taken <= 1'b1;
		end else if (no_idle || $urandom_range(0, 99) < 75) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b0;
			sink_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end
	end

	// Pack the request fields into tdata, lowest field first
	function automatic logic [23:0] pack_request(input logic [7:0] value,
			input logic [3:0] sel, input logic on, input logic fan_en,
			input logic [2:0] speed, input logic phase);
		return {6'd0, phase, speed, fan_en, on, sel, value};
	endfunction

	// Offer one request and hold it until accepted. Keep tvalid high across back-to-back
	// requests; drop it only for a real gap.
	task automatic send_request(input logic [2:0] cmd, input logic [23:0] req);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(6, 30);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= req;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [2:0] cmd;
		logic [7:0] value;
		logic [3:0] sel;
		int         r;
		int         counted;
		counted = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: init, percent icon then a number that clears it, channel bits that
		// the number wipes, blanking thresholds, wind and channel limits, ignored requests,
		// and every fan rotate case.
		send_request(CMD_INIT, pack_request(8'h00, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_ICON, pack_request(8'h00, ICON_PERCENT, 1'b1, 1'b0, 3'd0, 1'b0));
		send_request(CMD_CHANNEL, pack_request(8'd7, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_NUMBER, pack_request(8'd0, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_NUMBER, pack_request(8'd9, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_NUMBER, pack_request(8'd10, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_NUMBER, pack_request(8'd99, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_NUMBER, pack_request(8'd100, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_NUMBER, pack_request(8'd255, 4'hf, 1'b1, 1'b1, 3'd7, 1'b1));
		send_request(CMD_WIND, pack_request(8'd0, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_WIND, pack_request(8'd6, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_WIND, pack_request(8'd7, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_WIND, pack_request(8'd255, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_CHANNEL, pack_request(8'd0, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_CHANNEL, pack_request(8'd1, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_CHANNEL, pack_request(8'd8, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_CHANNEL, pack_request(8'd255, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_ICON, pack_request(8'h00, ICON_UNUSED, 1'b1, 1'b0, 3'd0, 1'b0));
		send_request(CMD_SPARE_6, pack_request(8'hff, 4'd3, 1'b1, 1'b1, 3'd3, 1'b1));
		send_request(CMD_SPARE_7, pack_request(8'h00, 4'd0, 1'b0, 1'b0, 3'd0, 1'b0));
		send_request(CMD_FAN, pack_request(8'h00, 4'd0, 1'b0, 1'b1, 3'd3, 1'b0));
		send_request(CMD_FAN, pack_request(8'h00, 4'd0, 1'b0, 1'b1, 3'd7, 1'b1));
		send_request(CMD_FAN, pack_request(8'h00, 4'd0, 1'b0, 1'b0, 3'd2, 1'b1));
		send_request(CMD_FAN, pack_request(8'h00, 4'd0, 1'b0, 1'b1, 3'd0, 1'b0));

		// Random part. Only requests that cause writes count toward the total.
		while (counted < RANDOM_ITEMS) begin
			// long receiver hold-off while the sender keeps offering back to back
			if (counted == 40) begin
				long_hold_req <= 1'b1;
				no_idle <= 1'b1;
			end
			if (counted == 70)
				no_idle <= 1'b0;
			// at a count of 90: stop offering and let every pending write drain before going on
			if (counted == 90) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				wait (writes_pending == 0);
				@(posedge clk);
			end
			// quiet stretch with no idling on either side
			if (counted == 100)
				no_idle <= 1'b1;
			if (counted == 110)
				no_idle <= 1'b0;

			r     = $urandom_range(0, 99);
			value = 8'($urandom_range(0, 255));
			sel   = 4'($urandom_range(0, ICON_LAST));
			if (r < 5)
				cmd = CMD_INIT;
			else if (r < 25)
				cmd = CMD_NUMBER;
			else if (r < 40)
				cmd = CMD_WIND;
			else if (r < 55)
				cmd = CMD_CHANNEL;
			else if (r < 80)
				cmd = CMD_ICON;
			else if (r < 95)
				cmd = CMD_FAN;
			else
				cmd = 3'($urandom_range(CMD_SPARE_6, CMD_SPARE_7));
			// keep most wind and channel values in range, some out of it
			if (cmd == CMD_WIND && $urandom_range(0, 3) != 0)
				value = 8'($urandom_range(0, WIND_MAX));
			if (cmd == CMD_CHANNEL && $urandom_range(0, 3) != 0)
				value = 8'($urandom_range(1, CHANNEL_MAX));
			if ($urandom_range(0, 7) == 0)
				sel = 4'($urandom_range(ICON_LAST + 1, 15));

			send_request(cmd, pack_request(value, sel, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
				1'($urandom_range(0, 1))));

			if (cmd <= CMD_FAN && !(cmd == CMD_ICON && sel > ICON_LAST))
				counted++;
		end
		s_axis_tvalid <= 1'b0;
		no_idle <= 1'b0;

		// Let the checker see the last request, then drain the write side
		@(posedge clk);
		wait (writes_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/slus_pkg.sv
hw/rtl/slus_front.sv
hw/rtl/slus_fifo.sv
hw/rtl/slus_back.sv
hw/rtl/segment_lcd_update_sequencer.sv
bench/slus_write_checker.sv
bench/segment_lcd_update_sequencer_tb.sv
